// ===== rtl/ptsc_pkg.sv =====
// Types, constants and shift helper shared by the time scaler modules.
package ptsc_pkg;

    localparam int unsigned DivSteps = 64;

    localparam logic [7:0] REG_REF_COUNT   = 8'd0;
    localparam logic [7:0] REG_REF_TIME    = 8'd1;
    localparam logic [7:0] REG_SCALE_MUL   = 8'd2;
    localparam logic [7:0] REG_SCALE_SHIFT = 8'd3;

    localparam logic FUNC_TO_TIME  = 1'b0;
    localparam logic FUNC_TO_COUNT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        func;
        logic        err;
        logic [63:0] fwd;
        logic [63:0] value;
    } front_t;

    typedef struct packed {
        logic        valid;
        logic        func;
        logic        err;
        logic [63:0] fwd;
        logic [31:0] rem;
        logic [63:0] work;
    } div_t;

    // Positive shift goes left unless invert is set; magnitude of 64 or more gives zero.
    function automatic logic [63:0] scale_shift_f(input logic [63:0] x, input logic [6:0] s,
                                                  input logic invert);
        logic [6:0] mag;
        logic       left;
        mag  = s[6] ? 7'(-s) : s;
        left = s[6] ? invert : !invert;
        if (mag[6])
            scale_shift_f = '0;
        else if (left)
            scale_shift_f = x << mag[5:0];
        else
            scale_shift_f = x >> mag[5:0];
    endfunction

endpackage

// ===== rtl/ptsc_front.sv =====
// Forward conversion pipeline: subtract, shift, multiply, add.
module ptsc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic                 in_func,
    input  logic [63:0]          in_value,
    input  logic [63:0]          ref_count,
    input  logic [63:0]          ref_time,
    input  logic [31:0]          scale_mul,
    input  logic [6:0]           scale_shift,
    output ptsc_pkg::front_t     out
);

    logic [3:0]  valid_reg;
    logic [2:0]  func_reg;
    logic [2:0]  err_reg;
    logic [63:0] value_reg [0:2];
    logic [63:0] d1_reg;
    logic [63:0] d2_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic        func4_reg;
    logic        err4_reg;
    logic [63:0] value4_reg;
    logic [63:0] fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func_reg     <= {func_reg[1:0], in_func};
            err_reg      <= {err_reg[1:0],
                             in_func & (in_value[63:32] >= scale_mul)};
            value_reg[0] <= in_value;
            value_reg[1] <= value_reg[0];
            value_reg[2] <= value_reg[1];
            d1_reg       <= in_value - ref_count;
            d2_reg       <= ptsc_pkg::scale_shift_f(d1_reg, scale_shift, 1'b0);
            lo_reg       <= 64'(d2_reg[31:0]) * 64'(scale_mul);
            hi_reg       <= 64'(d2_reg[63:32]) * 64'(scale_mul);
            fwd_reg      <= hi_reg + {32'd0, lo_reg[63:32]} + ref_time;
            func4_reg    <= func_reg[2];
            err4_reg     <= err_reg[2];
            value4_reg   <= value_reg[2];
        end
    end

    assign out.valid = valid_reg[3];
    assign out.func  = func4_reg;
    assign out.err   = err4_reg;
    assign out.fwd   = fwd_reg;
    assign out.value = value4_reg;

endmodule

// ===== rtl/ptsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ptsc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [31:0]       scale_mul,
    input  ptsc_pkg::front_t  in,
    output ptsc_pkg::div_t    out
);

    ptsc_pkg::div_t stage [0:ptsc_pkg::DivSteps];

    assign stage[0].valid = in.valid;
    assign stage[0].func  = in.func;
    assign stage[0].err   = in.err;
    assign stage[0].fwd   = in.fwd;
    assign stage[0].rem   = in.value[63:32];
    assign stage[0].work  = {in.value[31:0], 32'd0};

    for (genvar i = 0; i < ptsc_pkg::DivSteps; i++)
    begin : g_step
        logic [32:0]    trial;
        logic           qbit;
        ptsc_pkg::div_t nxt;
        ptsc_pkg::div_t st_reg;

        always_comb
        begin
            trial     = {stage[i].rem, stage[i].work[63]};
            qbit      = trial >= {1'b0, scale_mul};
            nxt       = stage[i];
            nxt.rem   = qbit ? 32'(trial - {1'b0, scale_mul}) : trial[31:0];
            nxt.work  = {stage[i].work[62:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg.valid <= 1'b0;
            else if (adv)
                st_reg <= nxt;
        end

        assign stage[i + 1] = st_reg;
    end

    assign out = stage[ptsc_pkg::DivSteps];

endmodule

// ===== rtl/pvclock_time_scaler.sv =====
// Top level of the counter/nanosecond time scaler.
// Converts a counter reading to nanoseconds (s_tuser = 0) or a nanosecond
// duration to counter ticks (s_tuser = 1), using the reference count,
// reference time, 0.32 multiplier and signed pre-shift in the registers.
// Input beats arrive on s_*, results leave on m_* with m_tuser as the
// error flag (zero multiplier or quotient overflow; m_tdata all ones).
// Registers are written on the cfg_* channel; the user must write them
// only while no beat is in flight; the block does not enforce it.
// The pipeline has four forward stages, 64 divider stages (one quotient
// bit each), one output shift/select stage and the output register. One
// beat is accepted per cycle while the output is taken. When m_tready is
// low with a result held, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated. Reset empties the pipeline and loads
// ref_count 0, ref_time 0, scale_mul 2^31 and scale_shift 1.
module pvclock_time_scaler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result
    output logic        m_tuser,   // error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]       ref_count_reg;
    logic [63:0]       ref_time_reg;
    logic [31:0]       scale_mul_reg;
    logic [6:0]        scale_shift_reg;
    logic              adv;
    ptsc_pkg::front_t  front;
    ptsc_pkg::div_t    divd;
    logic              post_valid_reg;
    logic [63:0]       post_res_reg;
    logic              post_err_reg;
    logic              out_valid_reg;
    logic [63:0]       out_data_reg;
    logic              out_err_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg   <= '0;
            ref_time_reg    <= '0;
            scale_mul_reg   <= 32'h8000_0000;
            scale_shift_reg <= 7'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptsc_pkg::REG_REF_COUNT:   ref_count_reg   <= cfg_data;
                ptsc_pkg::REG_REF_TIME:    ref_time_reg    <= cfg_data;
                ptsc_pkg::REG_SCALE_MUL:   scale_mul_reg   <= cfg_data[31:0];
                ptsc_pkg::REG_SCALE_SHIFT: scale_shift_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ptsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_tvalid),
        .in_func     (s_tuser),
        .in_value    (s_tdata),
        .ref_count   (ref_count_reg),
        .ref_time    (ref_time_reg),
        .scale_mul   (scale_mul_reg),
        .scale_shift (scale_shift_reg),
        .out         (front)
    );

    ptsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .scale_mul (scale_mul_reg),
        .in        (front),
        .out       (divd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            post_valid_reg <= divd.valid;
            out_valid_reg  <= post_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            post_err_reg <= divd.err;
            if (divd.err)
                post_res_reg <= '1;
            else if (divd.func == ptsc_pkg::FUNC_TO_COUNT)
                post_res_reg <= ptsc_pkg::scale_shift_f(divd.work, scale_shift_reg, 1'b1);
            else
                post_res_reg <= divd.fwd;
            out_data_reg <= post_res_reg;
            out_err_reg  <= post_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

// ===== tb/sv/tb_pvclock_time_scaler.sv =====
// Testbench for the counter/nanosecond time scaler: random and directed beats checked in order.
module tb_pvclock_time_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] result;
        logic        error;
    } conv_t;

    class conv_board;
        logic [63:0] ref_cnt;
        logic [63:0] ref_ns;
        logic [31:0] mul;
        logic [6:0]  shift;
        conv_t       pending[$];
        int          mismatches;
        int          checked;

        function void reset_regs();
            ref_cnt = '0;
            ref_ns  = '0;
            mul     = 32'h8000_0000;
            shift   = 7'd1;
        endfunction

        function void write_reg(logic [7:0] idx, logic [63:0] data);
            case (idx)
                ptsc_pkg::REG_REF_COUNT:   ref_cnt = data;
                ptsc_pkg::REG_REF_TIME:    ref_ns  = data;
                ptsc_pkg::REG_SCALE_MUL:   mul     = data[31:0];
                ptsc_pkg::REG_SCALE_SHIFT: shift   = data[6:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] shifted(logic [63:0] x, bit go_left, int unsigned n);
            if (n >= 64)
                return '0;
            return go_left ? x << n : x >> n;
        endfunction

        function conv_t convert(logic fn, logic [63:0] v);
            conv_t       c;
            logic [63:0] d;
            logic [127:0] prod;
            logic [95:0] num;
            logic [63:0] q;
            bit          neg;
            int unsigned mag;
            neg = shift[6];
            mag = neg ? 128 - shift : shift;
            c.error = 1'b0;
            if (fn == ptsc_pkg::FUNC_TO_TIME) begin
                d = shifted(v - ref_cnt, !neg, mag);
                prod = {64'd0, d} * {96'd0, mul};
                c.result = prod[95:32] + ref_ns;
            end else if (mul == 0 || v[63:32] >= mul) begin
                c.result = '1;
                c.error  = 1'b1;
            end else begin
                num = {v, 32'd0};
                q = 64'(num / {64'd0, mul});
                c.result = shifted(q, neg, mag);
            end
            return c;
        endfunction

        function void note_input(logic fn, logic [63:0] v);
            pending.push_back(convert(fn, v));
        endfunction

        function void check_result(logic [63:0] res, logic err);
            conv_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: result %h error %b", res, err);
                return;
            end
            e = pending.pop_front();
            if (e.result !== res || e.error !== err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b, got %h/%b",
                             e.result, e.error, res, err);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    pvclock_time_scaler dut (.*);

    always #10 clk = ~clk;

    conv_board board = new();
    int  idle_pct = 9;
    int  stall_cycles;
    int  sent_beats;
    bit  timed_out;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if (rst_n)
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000 && !timed_out) begin
            timed_out = 1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold valid between back-to-back beats; drop it only for idle cycles.
    task automatic send_beat(logic fn, logic [63:0] v);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1;
        s_tuser  <= fn;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        board.note_input(fn, v);
        sent_beats++;
    endtask

    task automatic write_cfg(logic [7:0] idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_scale(logic [63:0] rc, logic [63:0] rt, logic [31:0] m, logic [6:0] s);
        drain();
        write_cfg(ptsc_pkg::REG_REF_COUNT, rc);
        write_cfg(ptsc_pkg::REG_REF_TIME, rt);
        write_cfg(ptsc_pkg::REG_SCALE_MUL, {32'd0, m});
        write_cfg(ptsc_pkg::REG_SCALE_SHIFT, {57'd0, s});
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_ns(logic [31:0] m);
        logic [63:0] v;
        v = rand64();
        if ($urandom_range(9) < 8 && m != 0)
            v[63:32] = $urandom_range(m - 1, 0);
        return v;
    endfunction

    initial begin
        logic [31:0] m;
        logic [6:0]  s;
        board.reset_regs();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: default and extreme scale settings, extremes of value and both directions
        send_beat(ptsc_pkg::FUNC_TO_TIME, '0);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '1);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, '0);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'h8000_0000_0000_0000);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, '1);
        set_scale('1, '1, '1, 7'd32);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '0);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '1);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'hFFFF_FFFE_FFFF_FFFF);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, '1);
        set_scale(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 7'h60);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'd1);
        send_beat(ptsc_pkg::FUNC_TO_TIME, 64'h1234_5678_9ABC_DEF0);
        set_scale(64'd0, 64'd0, 32'd1, 7'h40);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '1);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'h0000_0000_FFFF_FFFF);
        set_scale(64'd7, 64'd9, 32'h0000_0003, 7'h3F);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '1);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'h0000_0002_8000_0000);
        set_scale(64'd0, 64'd0, 32'hFFFF_FFFF, 7'd64);
        send_beat(ptsc_pkg::FUNC_TO_TIME, '1);
        send_beat(ptsc_pkg::FUNC_TO_COUNT, 64'd12345);

        // random: ten scale settings, one of them a stretch with no idling
        for (int phase = 0; phase < 10; phase++) begin
            m = (phase == 3) ? 32'd0 : $urandom();
            if (phase == 5)
                m = $urandom_range(255, 1);
            s = ($urandom_range(9) == 0) ? 7'($urandom()) : 7'($urandom_range(64) - 32);
            set_scale(rand64(), rand64(), m, s);
            idle_pct = (phase == 7) ? 0 : 9;
            for (int i = 0; i < 53; i++) begin
                if ($urandom_range(1))
                    send_beat(ptsc_pkg::FUNC_TO_COUNT, rand_ns(m));
                else
                    send_beat(ptsc_pkg::FUNC_TO_TIME, rand64());
            end
        end
        idle_pct = 9;

        drain();
        $display("%0d beats sent over ten scale settings plus directed extremes;", sent_beats);
        $display("%0d results compared, both directions and error cases.", board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
